// ===== hw/rtl/wcp_pkg.sv =====
// Shared constants, types and the quarter-wave cosine table for the wall column projection.
package wcp_pkg;

    localparam int SCREEN_ROWS     = 720;
    localparam int TILE_SIZE       = 64;
    localparam int COS_TABLE_DEPTH = 1024;

    localparam int DIST_W  = 24;
    localparam int ANG_W   = 16;
    localparam int COORD_W = 16;
    localparam int HGT_W   = 16;
    localparam int ROW_W   = 10;
    localparam int TEXC_W  = 6;
    localparam int OFS_W   = 15;
    localparam int STEP_W  = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 80;

    localparam int COS_W  = 17;
    localparam int COS_AW = $clog2(COS_TABLE_DEPTH + 1);
    localparam int PHASE_W = 14;

    // Height divider: numerator is TILE_SIZE times the projection distance.
    localparam int NUM1_W     = DIST_W + $clog2(TILE_SIZE) + 1;
    localparam int D1_STAGES  = HGT_W / 2;
    localparam int D1_CMP_W   = DIST_W + HGT_W + 1;

    // Step divider: constant numerator TILE_SIZE in 8.16, divided by the height.
    localparam int STEP_QW    = $clog2(TILE_SIZE) + 17;
    localparam int D2_STAGES  = (STEP_QW + 1) / 2;
    localparam int D2_BITS    = 2 * D2_STAGES;
    localparam int D2_CMP_W   = HGT_W + D2_BITS;
    localparam logic [D2_CMP_W-1:0] STEP_NUM = D2_CMP_W'(TILE_SIZE) << 16;
    localparam logic [STEP_W-1:0]   STEP_MAX = 23'd4194304;
    localparam logic [HGT_W-1:0]    HEIGHT_MAX = 16'hFFFF;

    localparam int ROW_CALC_W = 17;
    localparam int MID_ROW    = SCREEN_ROWS / 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEW_ANGLE = 2'd0,
        CFG_PROJ_DIST  = 2'd1
    } cfg_reg_t;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    // Everything an item carries once its strip height is known.
    typedef struct packed {
        logic [HGT_W-1:0]  height;
        logic [ROW_W-1:0]  top;
        logic [ROW_W-1:0]  bottom;
        logic [TEXC_W-1:0] col;
        logic [OFS_W-1:0]  ofs;
    } row_info_t;

    typedef logic [COS_W-1:0] cos_t;
    typedef cos_t cos_rom_t [0:COS_TABLE_DEPTH];

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // Taylor sum of the cosine up to the x^16 term, in Q30, rounded to Q16.
    function automatic cos_t cos_entry(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        x   = (PI_HALF_Q30 * 64'(i)) / 64'(COS_TABLE_DEPTH);
        x2  = (x * x) >> 30;
        mag = 64'd1 << 30;
        sum = 64'sd1 << 30;
        mag = ((mag * x2) >> 30) / 64'd2;   sum = sum - signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd12;  sum = sum + signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd30;  sum = sum - signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd56;  sum = sum + signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd90;  sum = sum - signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd132; sum = sum + signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd182; sum = sum - signed'(mag);
        mag = ((mag * x2) >> 30) / 64'd240; sum = sum + signed'(mag);
        if (sum < 0) begin
            r = 0;
        end else begin
            r = (sum + 64'sd8192) >>> 14;
            if (r > 64'sd65536) begin
                r = 64'sd65536;
            end
        end
        return r[COS_W-1:0];
    endfunction

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t t;
        for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
            t[i] = cos_entry(i);
        end
        return t;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ===== hw/rtl/wall_column_projection.sv =====
// Throughput: one request per cycle; the height and step dividers are pipelined,
// two quotient bits per stage, and the cosine table read is registered.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset (aresetn low, synchronous) clears all valid bits and sets view_angle to 0
// and proj_plane_dist to 283785; the block accepts requests in the next cycle.
module wall_column_projection
    import wcp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // hit_distance[23:0], ray_dir[39:24], hit_x_int[55:40], hit_y_int[71:56]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // vert_hit[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // strip_height[15:0], top_row[25:16], bottom_row[35:26], tex_column[41:36],
    // tex_row_offset[56:42], tex_row_step[79:57]
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [ANG_W-1:0]  view_angle_reg;
    logic [DIST_W-1:0] proj_dist_reg;
    logic              ce;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_angle_reg <= '0;
            proj_dist_reg  <= 24'd283785;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_VIEW_ANGLE: view_angle_reg <= cfg_data[ANG_W-1:0];
                CFG_PROJ_DIST:  proj_dist_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // Stage 1: angle from the view direction, table address and texture column.
    logic [DIST_W-1:0]         in_dist;
    logic [ANG_W-1:0]          in_ang;
    logic [COORD_W-1:0]        in_hx;
    logic [COORD_W-1:0]        in_hy;
    logic [ANG_W-1:0]          ang_diff;
    logic [1:0]                quad;
    logic [PHASE_W+COS_AW-1:0] idx_prod;
    logic [COS_AW-1:0]         idx;
    logic [COORD_W-1:0]        coord;

    assign in_dist  = s_tdata[23:0];
    assign in_ang   = s_tdata[39:24];
    assign in_hx    = s_tdata[55:40];
    assign in_hy    = s_tdata[71:56];
    assign ang_diff = in_ang - view_angle_reg;
    assign quad     = ang_diff[ANG_W-1:PHASE_W];
    assign idx_prod = (PHASE_W+COS_AW)'(ang_diff[PHASE_W-1:0])
                    * (PHASE_W+COS_AW)'(COS_TABLE_DEPTH);
    assign idx      = idx_prod[PHASE_W+COS_AW-1:PHASE_W];
    assign coord    = s_tuser ? in_hy : in_hx;

    logic              s1_valid_reg;
    logic [COS_AW-1:0] s1_addr_reg;
    logic              s1_behind_reg;
    logic [DIST_W-1:0] s1_dist_reg;
    logic [TEXC_W-1:0] s1_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_addr_reg   <= (quad == QUAD_FOURTH) ? COS_AW'(COS_TABLE_DEPTH) - idx : idx;
            s1_behind_reg <= (quad != QUAD_FIRST) && (quad != QUAD_FOURTH);
            s1_dist_reg   <= in_dist;
            s1_col_reg    <= TEXC_W'(coord % TILE_SIZE);
        end
    end

    // Stage 2: registered cosine table read.
    logic              s2_valid_reg;
    cos_t              s2_cos_reg;
    logic [DIST_W-1:0] s2_dist_reg;
    logic [TEXC_W-1:0] s2_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (ce) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_cos_reg  <= s1_behind_reg ? '0 : COS_ROM[s1_addr_reg];
            s2_dist_reg <= s1_dist_reg;
            s2_col_reg  <= s1_col_reg;
        end
    end

    // Stage 3: perpendicular distance.
    logic [DIST_W+COS_W-1:0] perp_prod;
    logic                    s3_valid_reg;
    logic [DIST_W-1:0]       s3_perp_reg;
    logic [TEXC_W-1:0]       s3_col_reg;

    assign perp_prod = (DIST_W+COS_W)'(s2_dist_reg) * (DIST_W+COS_W)'(s2_cos_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (ce) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_perp_reg <= perp_prod[DIST_W+15:16];
            s3_col_reg  <= s2_col_reg;
        end
    end

    // Height divider. Entry 0 holds the overflow check; each later entry
    // resolves two quotient bits by restoring subtraction.
    logic [NUM1_W-1:0]   num1;
    logic [D1_CMP_W-1:0] num1_ext;
    logic [D1_CMP_W-1:0] perp_top;

    assign num1     = NUM1_W'(proj_dist_reg) * NUM1_W'(TILE_SIZE);
    assign num1_ext = D1_CMP_W'(num1);
    assign perp_top = D1_CMP_W'(s3_perp_reg) << HGT_W;

    logic                d1_valid_reg [0:D1_STAGES];
    logic [D1_CMP_W-1:0] d1_rem_reg   [0:D1_STAGES];
    logic [HGT_W-1:0]    d1_quo_reg   [0:D1_STAGES];
    logic [DIST_W-1:0]   d1_div_reg   [0:D1_STAGES];
    logic                d1_ovf_reg   [0:D1_STAGES];
    logic [TEXC_W-1:0]   d1_col_reg   [0:D1_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_valid_reg[0] <= 1'b0;
        end else if (ce) begin
            d1_valid_reg[0] <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d1_rem_reg[0] <= num1_ext;
            d1_quo_reg[0] <= '0;
            d1_div_reg[0] <= s3_perp_reg;
            d1_ovf_reg[0] <= (s3_perp_reg == '0) || (num1_ext >= perp_top);
            d1_col_reg[0] <= s3_col_reg;
        end
    end

    for (genvar j = 1; j <= D1_STAGES; j++) begin : g_div1
        localparam int BHI = HGT_W - 2 * j + 1;
        localparam int BLO = BHI - 1;
        logic [D1_CMP_W-1:0] sh_hi;
        logic [D1_CMP_W-1:0] sh_lo;
        logic [D1_CMP_W-1:0] rem_a;
        logic [D1_CMP_W-1:0] rem_b;
        logic                q_hi;
        logic                q_lo;
        logic [HGT_W-1:0]    quo_next;

        always_comb begin
            sh_hi    = D1_CMP_W'(d1_div_reg[j-1]) << BHI;
            q_hi     = d1_rem_reg[j-1] >= sh_hi;
            rem_a    = q_hi ? d1_rem_reg[j-1] - sh_hi : d1_rem_reg[j-1];
            sh_lo    = D1_CMP_W'(d1_div_reg[j-1]) << BLO;
            q_lo     = rem_a >= sh_lo;
            rem_b    = q_lo ? rem_a - sh_lo : rem_a;
            quo_next = d1_quo_reg[j-1];
            quo_next[BHI] = q_hi;
            quo_next[BLO] = q_lo;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d1_valid_reg[j] <= 1'b0;
            end else if (ce) begin
                d1_valid_reg[j] <= d1_valid_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                d1_rem_reg[j] <= rem_b;
                d1_quo_reg[j] <= quo_next;
                d1_div_reg[j] <= d1_div_reg[j-1];
                d1_ovf_reg[j] <= d1_ovf_reg[j-1];
                d1_col_reg[j] <= d1_col_reg[j-1];
            end
        end
    end

    // Row stage: rows and texture offset from the height; seeds the step divider.
    logic [HGT_W-1:0]      height;
    logic [ROW_CALC_W-1:0] half;
    logic [ROW_CALC_W-1:0] top_calc;
    logic [ROW_CALC_W-1:0] bot_calc;
    logic [ROW_CALC_W-1:0] ofs_calc;
    row_info_t             row_info;

    always_comb begin
        height = d1_ovf_reg[D1_STAGES] ? HEIGHT_MAX : d1_quo_reg[D1_STAGES];
        half   = ROW_CALC_W'(height >> 1);
        if (half > ROW_CALC_W'(MID_ROW)) begin
            top_calc = '0;
            ofs_calc = half - ROW_CALC_W'(MID_ROW);
        end else begin
            top_calc = ROW_CALC_W'(MID_ROW) - half;
            ofs_calc = '0;
        end
        bot_calc = ROW_CALC_W'(MID_ROW) + half;
        if (bot_calc > ROW_CALC_W'(SCREEN_ROWS)) begin
            bot_calc = ROW_CALC_W'(SCREEN_ROWS);
        end
        row_info.height = height;
        row_info.top    = top_calc[ROW_W-1:0];
        row_info.bottom = bot_calc[ROW_W-1:0];
        row_info.col    = d1_col_reg[D1_STAGES];
        row_info.ofs    = ofs_calc[OFS_W-1:0];
    end

    logic                d2_valid_reg [0:D2_STAGES];
    logic [D2_CMP_W-1:0] d2_rem_reg   [0:D2_STAGES];
    logic [D2_BITS-1:0]  d2_quo_reg   [0:D2_STAGES];
    row_info_t           d2_info_reg  [0:D2_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d2_valid_reg[0] <= 1'b0;
        end else if (ce) begin
            d2_valid_reg[0] <= d1_valid_reg[D1_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d2_rem_reg[0]  <= STEP_NUM;
            d2_quo_reg[0]  <= '0;
            d2_info_reg[0] <= row_info;
        end
    end

    for (genvar j = 1; j <= D2_STAGES; j++) begin : g_div2
        localparam int BHI = D2_BITS - 2 * j + 1;
        localparam int BLO = BHI - 1;
        logic [D2_CMP_W-1:0] sh_hi;
        logic [D2_CMP_W-1:0] sh_lo;
        logic [D2_CMP_W-1:0] rem_a;
        logic [D2_CMP_W-1:0] rem_b;
        logic                q_hi;
        logic                q_lo;
        logic [D2_BITS-1:0]  quo_next;

        always_comb begin
            sh_hi    = D2_CMP_W'(d2_info_reg[j-1].height) << BHI;
            q_hi     = (d2_info_reg[j-1].height != '0) && (d2_rem_reg[j-1] >= sh_hi);
            rem_a    = q_hi ? d2_rem_reg[j-1] - sh_hi : d2_rem_reg[j-1];
            sh_lo    = D2_CMP_W'(d2_info_reg[j-1].height) << BLO;
            q_lo     = (d2_info_reg[j-1].height != '0) && (rem_a >= sh_lo);
            rem_b    = q_lo ? rem_a - sh_lo : rem_a;
            quo_next = d2_quo_reg[j-1];
            quo_next[BHI] = q_hi;
            quo_next[BLO] = q_lo;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d2_valid_reg[j] <= 1'b0;
            end else if (ce) begin
                d2_valid_reg[j] <= d2_valid_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                d2_rem_reg[j]  <= rem_b;
                d2_quo_reg[j]  <= quo_next;
                d2_info_reg[j] <= d2_info_reg[j-1];
            end
        end
    end

    // Output register: saturate the step; a zero height takes the maximum.
    logic [STEP_W-1:0] step;
    row_info_t         fin;
    logic              out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    assign fin = d2_info_reg[D2_STAGES];

    always_comb begin
        if ((fin.height == '0) || (d2_quo_reg[D2_STAGES] > D2_BITS'(STEP_MAX))) begin
            step = STEP_MAX;
        end else begin
            step = d2_quo_reg[D2_STAGES][STEP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= d2_valid_reg[D2_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_data_reg <= {step, fin.ofs, fin.col, fin.bottom, fin.top, fin.height};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hw/rtl/wcp_checker.sv =====
// Port-level checks for the wall column projection, bound to the top level.
module wcp_checker
    import wcp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_DATA_W-1:0]   s_tdata,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // A held result keeps its value until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An empty output register never blocks new requests.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // The strip never starts below its end, and ends on the screen.
    a_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:16] <= m_tdata[35:26])
                  && (m_tdata[35:26] <= ROW_W'(SCREEN_ROWS)))
        else $error("row range out of order");

    // A zero height gives the saturated step.
    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[15:0] == '0) |-> (m_tdata[79:57] == STEP_MAX))
        else $error("step not saturated for zero height");

    // Nothing comes out in the cycle after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind wall_column_projection wcp_checker u_wcp_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the wall column projection block.
`timescale 1ns / 100ps

module testbench;
    import wcp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [DIST_W-1:0]  distance;
        logic [ANG_W-1:0]   angle;
        logic               vertical;
        logic [COORD_W-1:0] hx;
        logic [COORD_W-1:0] hy;
    } wall_hit_t;

    typedef struct {
        logic [HGT_W-1:0]  height;
        logic [ROW_W-1:0]  top;
        logic [ROW_W-1:0]  bottom;
        logic [TEXC_W-1:0] col;
        logic [OFS_W-1:0]  ofs;
        logic [STEP_W-1:0] step;
    } column_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [16:0]           cosine_q16 [0:COS_TABLE_DEPTH];
    logic [ANG_W-1:0]      facing = '0;
    logic [DIST_W-1:0]     plane_dist = 24'd283785;
    column_t               pending_columns [$];
    int                    errors = 0;
    bit                    idling = 1'b1;

    wall_column_projection u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // Q30 Taylor series of the cosine, rounded to Q16.
    function automatic logic [16:0] taylor_cos(input int unsigned i);
        logic [63:0]     x;
        logic [63:0]     x2;
        logic [63:0]     term;
        longint          acc;
        longint          rounded;
        x = (64'd1686629713 * 64'(i)) / 64'(COS_TABLE_DEPTH);
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        acc = longint'(1) << 30;
        for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        if (acc < 0) return 17'd0;
        rounded = (acc + 8192) >>> 14;
        if (rounded > 65536) rounded = 65536;
        return rounded[16:0];
    endfunction

    function automatic column_t project_column(input wall_hit_t h);
        column_t     r;
        logic [15:0] rel;
        logic [63:0] c, perp, hgt, half, top, bottom, step, coord;
        rel = h.angle - facing;
        c = 0;
        if (rel[15:14] == QUAD_FIRST) c = cosine_q16[rel[13:0] >> 4];
        else if (rel[15:14] == QUAD_FOURTH) c = cosine_q16[COS_TABLE_DEPTH - (rel[13:0] >> 4)];
        perp = (64'(h.distance) * c) >> 16;
        if (perp == 0) begin
            hgt = 65535;
        end else begin
            hgt = (64'(TILE_SIZE) * 64'(plane_dist)) / perp;
            if (hgt > 65535) hgt = 65535;
        end
        half = hgt / 2;
        top = (half > MID_ROW) ? 0 : MID_ROW - half;
        bottom = MID_ROW + half;
        if (bottom > SCREEN_ROWS) bottom = SCREEN_ROWS;
        if (hgt == 0) begin
            step = 4194304;
        end else begin
            step = (64'(TILE_SIZE) << 16) / hgt;
            if (step > 4194304) step = 4194304;
        end
        coord = h.vertical ? h.hy : h.hx;
        r.height = hgt[15:0];
        r.top = top[9:0];
        r.bottom = bottom[9:0];
        r.col = 6'(coord % TILE_SIZE);
        r.ofs = 15'(top + half - MID_ROW);
        r.step = step[22:0];
        return r;
    endfunction

    // Result checker: every accepted column is matched against the oldest prediction.
    always @(posedge aclk) begin
        column_t want;
        column_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.height = m_tdata[15:0];
            got.top    = m_tdata[25:16];
            got.bottom = m_tdata[35:26];
            got.col    = m_tdata[41:36];
            got.ofs    = m_tdata[56:42];
            got.step   = m_tdata[79:57];
            if (pending_columns.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_columns.pop_front();
                if (got.height !== want.height) begin
                    $display("%0t: height expected %0d actual %0d", $time, want.height, got.height);
                    errors++;
                end
                if (got.top !== want.top) begin
                    $display("%0t: top expected %0d actual %0d", $time, want.top, got.top);
                    errors++;
                end
                if (got.bottom !== want.bottom) begin
                    $display("%0t: bottom expected %0d actual %0d", $time, want.bottom, got.bottom);
                    errors++;
                end
                if (got.col !== want.col) begin
                    $display("%0t: column expected %0d actual %0d", $time, want.col, got.col);
                    errors++;
                end
                if (got.ofs !== want.ofs) begin
                    $display("%0t: offset expected %0d actual %0d", $time, want.ofs, got.ofs);
                    errors++;
                end
                if (got.step !== want.step) begin
                    $display("%0t: step expected %0d actual %0d", $time, want.step, got.step);
                    errors++;
                end
            end
        end
    end

    // Receiver back-pressure in random bursts while idling is set.
    initial begin
        forever begin
            @(negedge aclk);
            if (idling && $urandom_range(0, 2) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge aclk);
        end
    end

    task automatic send_hit(input wall_hit_t h);
        @(negedge aclk);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tdata = {h.hy, h.hx, h.angle, h.distance};
        s_tuser = h.vertical;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_columns.push_back(project_column(h));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending_columns.size() == 0);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_VIEW_ANGLE) facing = val[15:0];
        else if (idx == CFG_PROJ_DIST) plane_dist = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic wall_hit_t random_hit();
        wall_hit_t h;
        h.distance = $urandom();
        h.angle = $urandom();
        h.vertical = $urandom_range(0, 1);
        h.hx = $urandom();
        h.hy = $urandom();
        return h;
    endfunction

    // Mostly plausible hits: distances of a few tiles, angles inside the field of view.
    function automatic wall_hit_t scene_hit();
        wall_hit_t h;
        h = random_hit();
        case ($urandom_range(0, 3))
            0: h.distance = $urandom_range(0, 4096);
            1: h.distance = $urandom_range(256, 64 * 256 * 32);
            2: h.distance = $urandom_range(4096, 64 * 256 * 4);
            default: ;
        endcase
        if ($urandom_range(0, 3) != 0) h.angle = facing + 16'($urandom_range(0, 12000)) - 16'd6000;
        return h;
    endfunction

    task automatic test_directed_extremes();
        wall_hit_t h;
        h = '{24'd0, 16'd0, 1'b0, 16'd0, 16'd0};
        send_hit(h);
        h = '{24'hFFFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF};
        send_hit(h);
        // Both sides of every quadrant boundary and quadrant midpoint, ray behind included.
        for (int a = 0; a < 8; a++) begin
            h = '{24'd16384, 16'(a * 8192), 1'(a), 16'(a * 37), 16'(a * 91)};
            send_hit(h);
            h.angle = 16'(a * 8192 - 1);
            send_hit(h);
        end
        h = '{24'd1, 16'd0, 1'b0, 16'd63, 16'd64};
        send_hit(h);
        h = '{24'd256, 16'd0, 1'b1, 16'd64, 16'd127};
        send_hit(h);
        h = '{24'd4540560, 16'd0, 1'b0, 16'd5, 16'd9};
        send_hit(h);
    endtask

    task automatic test_register_settings();
        write_reg(CFG_VIEW_ANGLE, 24'h00FFFF);
        write_reg(CFG_PROJ_DIST, 24'd0);
        for (int n = 0; n < 6; n++) send_hit(scene_hit());
        write_reg(CFG_PROJ_DIST, 24'hFFFFFF);
        write_reg(CFG_UNUSED_A, 24'h123456);
        write_reg(CFG_UNUSED_B, 24'hABCDEF);
        for (int n = 0; n < 6; n++) send_hit(scene_hit());
        // Height of exactly one row gives the largest unsaturated step.
        write_reg(CFG_VIEW_ANGLE, 24'd0);
        write_reg(CFG_PROJ_DIST, 24'd4);
        send_hit('{24'd256, 16'd0, 1'b0, 16'd1, 16'd2});
        send_hit('{24'd257, 16'd0, 1'b1, 16'd1, 16'd2});
    endtask

    task automatic test_random_phases();
        logic [23:0] plane_choices [4] = '{24'd283785, 24'd1, 24'hFFFFFF, 24'd65536};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_VIEW_ANGLE, 24'($urandom()));
            write_reg(CFG_PROJ_DIST, $urandom_range(0, 1) ? plane_choices[ph] : 24'($urandom()));
            for (int n = 0; n < 230; n++) begin
                send_hit($urandom_range(0, 4) == 0 ? random_hit() : scene_hit());
            end
        end
    endtask

    task automatic test_full_rate();
        write_reg(CFG_PROJ_DIST, 24'd283785);
        idling = 1'b0;
        for (int n = 0; n < 90; n++) send_hit(scene_hit());
    endtask

    initial begin
        for (int i = 0; i <= COS_TABLE_DEPTH; i++) cosine_q16[i] = taylor_cos(i);
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed_extremes();
        test_register_settings();
        test_random_phases();
        test_full_rate();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending_columns.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
